@@ rtl/core/frr_pkg.sv @@
`default_nettype none
package frr_pkg;

  localparam int NumClasses = 12;
  localparam int MaxUnits   = 4;
  localparam int CycleBits  = 32;
  localparam int NumRegs    = 3;
  localparam int RegW       = 60;
  localparam int FieldW     = 15;
  localparam int ClassAw    = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int UnitW      = (MaxUnits > 1) ? $clog2(MaxUnits) : 1;
  localparam int CfgIdxW    = 2;

  typedef logic [NumRegs-1:0][RegW-1:0] params_t;

  localparam params_t ParamReset = {
    60'd731881291978934826, 60'd91550855031292436, 60'd347938832203252244
  };

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_STATS   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef logic [CycleBits-1:0] cycle_t;
  typedef cycle_t [MaxUnits-1:0] free_row_t;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  unit_class;
    logic [31:0] current_cycle;
    logic [31:0] first_try_cycle;
  } in_t;

  typedef struct packed {
    logic [5:0]  granted_latency;
    logic [1:0]  unit_index;
    logic [31:0] try_cycle_out;
    logic [31:0] grant_count;
    logic [47:0] wait_total;
    logic [31:0] deny_count;
  } out_t;

  typedef struct packed {
    logic [31:0] grants;
    logic [47:0] waits;
    logic [31:0] denials;
  } stat_row_t;

  typedef struct packed {
    logic               en;
    logic [ClassAw-1:0] addr;
    logic               grant;
    cycle_t             wait_cyc;
  } stat_upd_t;

  function automatic logic class_ok(logic [3:0] c);
    return (int'(c) < NumClasses) && (int'(c) < NumRegs * 4);
  endfunction

  function automatic logic [ClassAw-1:0] class_addr(logic [3:0] c);
    return class_ok(c) ? ClassAw'(c) : '0;
  endfunction

  // count [2:0], op latency [8:3], issue latency [14:9]
  function automatic logic [FieldW-1:0] class_field(params_t p, logic [3:0] c);
    logic [RegW-1:0] r;
    r = (int'(c[3:2]) < NumRegs) ? p[c[3:2]] : '0;
    return r[c[1:0]*FieldW +: FieldW];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/frr_free_table.sv @@
`default_nettype none
module frr_free_table (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire [frr_pkg::ClassAw-1:0]  rd_addr_i,
  input  wire                         wr_en_i,
  input  wire [frr_pkg::ClassAw-1:0]  wr_addr_i,
  input  frr_pkg::free_row_t          wr_row_i,
  input  wire                         clr_all_i,
  output frr_pkg::free_row_t          rd_row_o
);
  import frr_pkg::*;

  free_row_t             mem_q [NumClasses];
  free_row_t             rd_q;
  logic [NumClasses-1:0] vld_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // a row not written since reset or release-all reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (clr_all_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

@@ rtl/core/frr_stats.sv @@
`default_nettype none
module frr_stats (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire [frr_pkg::ClassAw-1:0]  rd_addr_i,
  input  frr_pkg::stat_upd_t          upd_i,
  output frr_pkg::stat_row_t          rd_row_o
);
  import frr_pkg::*;

  stat_row_t             mem_q [NumClasses];
  stat_row_t             rd_q;
  stat_row_t             row;
  stat_row_t             new_row;
  logic [NumClasses-1:0] vld_q;
  logic                  rd_vld_q;
  logic [48:0]           wait_sum;

  assign row      = rd_vld_q ? rd_q : '0;
  assign rd_row_o = row;

  // saturating read-modify-write on the row read in the previous cycle
  always_comb begin
    new_row  = row;
    wait_sum = {1'b0, row.waits} + 49'(upd_i.wait_cyc);
    if (upd_i.grant) begin
      if (row.grants != '1) begin
        new_row.grants = row.grants + 32'd1;
      end
      new_row.waits = wait_sum[48] ? '1 : wait_sum[47:0];
    end else if (row.denials != '1) begin
      new_row.denials = row.denials + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en) begin
      mem_q[upd_i.addr] <= new_row;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (upd_i.en) begin
        vld_q[upd_i.addr] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/functional_unit_reservation.sv @@
// Flow: the class rows are read at the input transfer, then updated and written back in
//   the execute state, which holds while the output register is not drained.
// One item at a time: no new input is taken until the read-modify-write of a class row
//   in the free-at and statistics memories is done.
// Reset: all units free, all counters zero, class parameters at defaults.
`default_nettype none
module functional_unit_reservation (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  frr_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output frr_pkg::out_t                out_data_o,
  input  wire                          cfg_we_i,
  input  wire [frr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [frr_pkg::RegW-1:0]      cfg_wdata_i
);
  import frr_pkg::*;

  state_e              state_q, state_d;
  in_t                 item_q;
  params_t             params_q;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                in_xfer, exec_done;

  logic [ClassAw-1:0]  rd_addr;
  free_row_t           free_row, free_wr_row;
  stat_row_t           stat_row;
  stat_upd_t           stat_upd;
  logic                free_we, clr_all;

  logic [FieldW-1:0]   field;
  logic [2:0]          cnt;
  logic [5:0]          oplat, islat;
  cycle_t              now, first, tryc, wait_cyc;
  logic [MaxUnits-1:0] avail;
  logic [UnitW-1:0]    pick;
  logic                found, granted, ok, is_res;

  // FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_EXEC;
      ST_EXEC: if (exec_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    exec_done  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: exec_done = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_xfer = in_valid_i && in_ready_o;
  assign rd_addr = (state_q == ST_IDLE) ? class_addr(in_data_i.unit_class)
                                        : class_addr(item_q.unit_class);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      params_q    <= ParamReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (int'(cfg_idx_i) < NumRegs)) begin
        params_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    if (exec_done) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // unit selection on the row read for this item
  assign ok     = class_ok(item_q.unit_class);
  assign is_res = (item_q.command == CMD_RESERVE);
  assign field  = class_field(params_q, item_q.unit_class);
  assign cnt    = field[2:0];
  assign oplat  = field[8:3];
  assign islat  = field[14:9];
  assign now    = CycleBits'(item_q.current_cycle);
  assign first  = CycleBits'(item_q.first_try_cycle);
  assign tryc   = (first != '0) ? first : now;
  assign wait_cyc = (tryc <= now) ? cycle_t'(now - tryc) : '0;

  always_comb begin
    for (int i = 0; i < MaxUnits; i++) begin
      avail[i] = (i < int'(cnt)) && (free_row[i] <= now);
    end
  end

  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = MaxUnits - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pick  = UnitW'(i);
        found = 1'b1;
      end
    end
  end

  assign granted = found && (oplat != '0) && (islat != '0);

  always_comb begin
    free_wr_row       = free_row;
    free_wr_row[pick] = cycle_t'(now + cycle_t'(islat));
  end

  assign free_we = exec_done && is_res && ok && granted;
  assign clr_all = exec_done && (item_q.command == CMD_RELEASE);

  always_comb begin
    stat_upd.en       = exec_done && is_res && ok;
    stat_upd.addr     = class_addr(item_q.unit_class);
    stat_upd.grant    = granted;
    stat_upd.wait_cyc = wait_cyc;
  end

  always_comb begin
    out_d = '0;
    case (item_q.command)
      CMD_RESERVE: begin
        out_d.try_cycle_out = 32'(tryc);
        if (ok && granted) begin
          out_d.granted_latency = oplat;
          out_d.unit_index      = 2'(pick);
        end
      end
      CMD_STATS: begin
        if (ok) begin
          out_d.grant_count = stat_row.grants;
          out_d.wait_total  = stat_row.waits;
          out_d.deny_count  = stat_row.denials;
        end
      end
      default: ;
    endcase
  end

  frr_free_table u_free (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (free_we),
    .wr_addr_i (class_addr(item_q.unit_class)),
    .wr_row_i  (free_wr_row),
    .clr_all_i (clr_all),
    .rd_row_o  (free_row)
  );

  frr_stats u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .upd_i     (stat_upd),
    .rd_row_o  (stat_row)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/core/frr_checker.sv @@
`default_nettype none
module frr_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_o,
  input wire           out_valid_o,
  input wire           out_ready_i,
  input frr_pkg::out_t out_data_o
);
  import frr_pkg::*;

  // one item in flight: no second transfer right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_denied_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.granted_latency == '0) |-> out_data_o.unit_index == '0)
    else $error("unit index on a denial");

  // reserve results never carry counters
  a_res_no_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.try_cycle_out != '0) |->
      (out_data_o.grant_count == '0) && (out_data_o.wait_total == '0) &&
      (out_data_o.deny_count == '0))
    else $error("counters on a reserve result");

endmodule

bind functional_unit_reservation frr_checker u_frr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
